FILE: hw/rtl/jqc_pkg.sv
// Shared types, constants and helpers for the job queue with cancel.
// Used by job_queue_with_cancel_core and the test files; depends on nothing.
package jqc_pkg;

	localparam int DEPTH        = 16;
	localparam int TAG_BITS     = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam int ENTRY_BITS   = TAG_BITS + PAYLOAD_BITS;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int CAP_W        = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Operation codes
	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	// Status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Circular increment within the active capacity
	function automatic idx_t wrap_next(input idx_t i, input cnt_t cap);
		cnt_t n;
		n = CNT_W'(i) + cnt_t'(1);
		return (n >= cap) ? '0 : n[IDX_W-1:0];
	endfunction

	// Clamp a written capacity to 1..DEPTH
	function automatic cnt_t clamp_cap(input logic [CAP_W-1:0] c);
		cnt_t r;
		if (c == '0) begin
			r = cnt_t'(1);
		end else if (32'(c) > DEPTH) begin
			r = cnt_t'(DEPTH);
		end else begin
			r = cnt_t'(c);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/jqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module jqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/job_queue_with_cancel_core.sv
// Job queue with cancel by tag: push, pop, cancel over a circular RAM queue.
// Push and refused or ignored operations: result strobe in the cycle after start, back to back.
// Pop: result follows the registered RAM read and the S_POP state; busy for 1 cycle.
// Cancel: busy while it searches entries from the head and then moves each later entry down one
// slot; on an empty queue it reports not found without going busy.
// Reset (arst_n low) empties the queue and sets capacity to 16; RAM contents are not cleared.
// Results cannot be stalled: each is shown for one cycle with done high.
module job_queue_with_cancel_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic [31:0]                 job_tag,
	input  logic [31:0]                 job_payload,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [31:0]                 out_tag,
	output logic [31:0]                 out_payload,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [jqc_pkg::CAP_W-1:0]   cfg_data
);

	import jqc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POP   = 2'd1;
	localparam logic [1:0] S_SRCH  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]          state_q;
	idx_t                head_q, tail_q, pos_q;
	cnt_t                fill_q, cap_q, off_q, rem_q;
	logic [TAG_BITS-1:0] key_q;

	logic                  accept;
	logic                  ram_we;
	idx_t                  ram_waddr, ram_raddr, pos_nx;
	logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
	logic [TAG_BITS-1:0]   rd_tag;
	logic                  hit;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = start && !busy;
	assign pos_nx    = wrap_next(pos_q, cap_q);
	assign rd_tag    = ram_rdata[ENTRY_BITS-1:PAYLOAD_BITS];
	assign hit       = (rd_tag == key_q);

	// Read address: head when idle, the slot after pos_q while searching, the one after that while shifting
	always_comb begin
		case (state_q)
			S_SRCH:  ram_raddr = pos_nx;
			S_SHIFT: ram_raddr = wrap_next(pos_nx, cap_q);
			default: ram_raddr = head_q;
		endcase
	end

	// Write: push at tail, or move the later entry down one slot while shifting
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {job_tag[TAG_BITS-1:0], job_payload[PAYLOAD_BITS-1:0]};
		if (state_q == S_SHIFT) begin
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = ram_rdata;
		end else if (accept && kind == KIND_PUSH && fill_q < cap_q) begin
			ram_we = 1'b1;
		end
	end

	jqc_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			cap_q       <= cnt_t'(DEPTH);
			pos_q       <= '0;
			off_q       <= '0;
			rem_q       <= '0;
			key_q       <= '0;
			done        <= 1'b0;
			status      <= ST_DONE;
			out_tag     <= '0;
			out_payload <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					// capacity write empties the queue
					if (cfg_valid) begin
						cap_q  <= clamp_cap(cfg_data);
						head_q <= '0;
						tail_q <= '0;
						fill_q <= '0;
					end
					if (accept) begin
						out_tag     <= '0;
						out_payload <= '0;
						status      <= ST_DONE;
						key_q       <= job_tag[TAG_BITS-1:0];
						case (kind)
							KIND_PUSH: begin
								done <= 1'b1;
								if (fill_q >= cap_q) begin
									status <= ST_FULL;
								end else begin
									tail_q <= wrap_next(tail_q, cap_q);
									fill_q <= fill_q + cnt_t'(1);
								end
							end
							KIND_POP: begin
								if (fill_q == '0) begin
									done   <= 1'b1;
									status <= ST_EMPTY;
								end else begin
									state_q <= S_POP;
								end
							end
							KIND_CANCEL: begin
								if (fill_q == '0) begin
									done   <= 1'b1;
									status <= ST_NOT_FOUND;
								end else begin
									pos_q   <= head_q;
									off_q   <= '0;
									state_q <= S_SRCH;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					done        <= 1'b1;
					out_tag     <= ram_rdata[ENTRY_BITS-1:PAYLOAD_BITS];
					out_payload <= ram_rdata[PAYLOAD_BITS-1:0];
					head_q      <= wrap_next(head_q, cap_q);
					fill_q      <= fill_q - cnt_t'(1);
					state_q     <= S_IDLE;
				end
				S_SRCH: begin
					if (hit) begin
						rem_q <= fill_q - cnt_t'(1) - off_q;
						if (fill_q - cnt_t'(1) == off_q) begin
							// match is the newest entry: nothing to shift
							done    <= 1'b1;
							tail_q  <= (tail_q == '0) ? IDX_W'(cap_q - cnt_t'(1))
							                          : tail_q - idx_t'(1);
							fill_q  <= fill_q - cnt_t'(1);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (off_q + cnt_t'(1) == fill_q) begin
						done    <= 1'b1;
						status  <= ST_NOT_FOUND;
						state_q <= S_IDLE;
					end else begin
						pos_q <= pos_nx;
						off_q <= off_q + cnt_t'(1);
					end
				end
				S_SHIFT: begin
					// entry at pos_nx written to pos_q this cycle
					pos_q <= pos_nx;
					rem_q <= rem_q - cnt_t'(1);
					if (rem_q == cnt_t'(1)) begin
						done    <= 1'b1;
						tail_q  <= (tail_q == '0) ? IDX_W'(cap_q - cnt_t'(1))
						                          : tail_q - idx_t'(1);
						fill_q  <= fill_q - cnt_t'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: test/jqc_queue_checker.sv
// Checker for the job queue with cancel: watches job, result and capacity beats,
// keeps a shadow queue, predicts each result and compares it. Depends on jqc_pkg.
module jqc_queue_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [31:0]                job_tag,
	input  logic [31:0]                job_payload,
	input  logic                       done,
	input  logic [1:0]                 status,
	input  logic [31:0]                out_tag,
	input  logic [31:0]                out_payload,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [jqc_pkg::CAP_W-1:0]  cfg_data,
	output int                         fail_count,
	output int                         pending
);

	import jqc_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] tag;
		logic [31:0] payload;
	} job_result_t;

	// Shadow copy of the queue
	logic [31:0]      shadow_tags [DEPTH];
	logic [31:0]      shadow_pays [DEPTH];
	int               shadow_head;
	int               shadow_tail;
	int               shadow_fill;
	logic [CAP_W-1:0] shadow_cap;

	job_result_t awaited_results [$];

	function automatic int next_slot(input int i, input int c);
		return (i + 1 >= c) ? 0 : i + 1;
	endfunction

	// Apply one job to the shadow queue and work out its result
	task automatic predict_job(input logic [1:0] k, input logic [31:0] t,
			input logic [31:0] p, output job_result_t r);
		int  ecap;
		int  pos;
		int  off;
		int  nx;
		int  n;
		bit  hit;
		r = '0;
		r.status = ST_DONE;
		ecap = (shadow_cap == 0) ? 1 : (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
		// pointers stay inside the active capacity
		if (shadow_head >= ecap) shadow_head = 0;
		if (shadow_tail >= ecap) shadow_tail = 0;
		if (shadow_fill > ecap) shadow_fill = ecap;
		case (k)
			KIND_PUSH: begin
				if (shadow_fill >= ecap) begin
					r.status = ST_FULL;
				end else begin
					shadow_tags[shadow_tail] = t;
					shadow_pays[shadow_tail] = p;
					shadow_tail = next_slot(shadow_tail, ecap);
					shadow_fill++;
				end
			end
			KIND_POP: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.tag = shadow_tags[shadow_head];
					r.payload = shadow_pays[shadow_head];
					shadow_head = next_slot(shadow_head, ecap);
					shadow_fill--;
				end
			end
			KIND_CANCEL: begin
				pos = shadow_head;
				off = 0;
				hit = 1'b0;
				while (!hit && off < shadow_fill) begin
					if (shadow_tags[pos] == t) begin
						hit = 1'b1;
					end else begin
						pos = next_slot(pos, ecap);
						off++;
					end
				end
				if (!hit) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap: later entries move one slot toward the head
					for (n = 0; n < shadow_fill - 1 - off; n++) begin
						nx = next_slot(pos, ecap);
						shadow_tags[pos] = shadow_tags[nx];
						shadow_pays[pos] = shadow_pays[nx];
						pos = nx;
					end
					shadow_tail = (shadow_tail == 0) ? ecap - 1 : shadow_tail - 1;
					shadow_fill--;
				end
			end
			default: begin
				// unused kind leaves the queue alone
			end
		endcase
	endtask

	// Watch all three channels on each rising edge
	always @(posedge clk) begin : watch
		job_result_t want;
		if (!arst_n) begin
			shadow_head = 0;
			shadow_tail = 0;
			shadow_fill = 0;
			shadow_cap = CAP_W'(16);
			awaited_results.delete();
			fail_count = 0;
		end else begin
			// result beat against the oldest expectation
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with no job awaiting it: status %0d tag %h payload %h",
						status, out_tag, out_payload);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (out_tag !== want.tag) begin
						$error("out_tag: expected %h, got %h", want.tag, out_tag);
						fail_count++;
					end
					if (out_payload !== want.payload) begin
						$error("out_payload: expected %h, got %h", want.payload, out_payload);
						fail_count++;
					end
				end
			end
			// capacity write also empties the queue
			if (cfg_valid && cfg_ready) begin
				shadow_cap = cfg_data;
				shadow_head = 0;
				shadow_tail = 0;
				shadow_fill = 0;
			end
			// job beat
			if (start && !busy) begin
				predict_job(kind, job_tag, job_payload, want);
				awaited_results.push_back(want);
			end
		end
		pending = awaited_results.size();
	end

endmodule

FILE: test/job_queue_with_cancel_core_test.sv
// Testbench top for job_queue_with_cancel_core: drives directed and random job
// beats and capacity writes; jqc_queue_checker predicts and compares results.
module job_queue_with_cancel_core_test;
	import jqc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        kind;
	logic [31:0]       job_tag;
	logic [31:0]       job_payload;
	logic              done;
	logic [1:0]        status;
	logic [31:0]       out_tag;
	logic [31:0]       out_payload;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;
	int                fail_count;
	int                pending;

	always #1 clk = ~clk;

	job_queue_with_cancel_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.job_tag     (job_tag),
		.job_payload (job_payload),
		.done        (done),
		.status      (status),
		.out_tag     (out_tag),
		.out_payload (out_payload),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	jqc_queue_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.job_tag     (job_tag),
		.job_payload (job_payload),
		.done        (done),
		.status      (status),
		.out_tag     (out_tag),
		.out_payload (out_payload),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// One job beat: hold start until the block takes it
	task automatic issue_job(input logic [1:0] k, input logic [31:0] t, input logic [31:0] p);
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		job_tag <= t;
		job_payload <= p;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Stop sending and wait for every awaited result, then let the block settle
	task automatic drain_jobs();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		drain_jobs();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus
	initial begin
		logic [31:0]      tag_pool [8];
		logic [CAP_W-1:0] cap;
		logic [31:0]      t;
		int               push_w;
		int               r;
		int               burst_left;
		bit               quiet;

		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_PUSH;
		job_tag = '0;
		job_payload = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty queue refusals, duplicate tags, cancel with shift, unused kind
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_CANCEL, 32'h0, 32'h0);
		issue_job(KIND_PUSH, 32'h0000_0000, 32'h0000_0000);
		issue_job(KIND_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_job(KIND_PUSH, 32'h1234_5678, 32'hA5A5_A5A5);
		issue_job(KIND_PUSH, 32'hFFFF_FFFF, 32'h0000_0001);
		issue_job(KIND_CANCEL, 32'hFFFF_FFFF, 32'h0);
		issue_job(KIND_CANCEL, 32'hDEAD_BEEF, 32'h0);
		issue_job(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_PUSH, 32'hCAFE_F00D, 32'h0000_0005);

		// capacity zero acts as one; the write drops the entry left behind
		write_capacity(CAP_W'(0));
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_PUSH, 32'h1, 32'h2);
		issue_job(KIND_PUSH, 32'h3, 32'h4);
		issue_job(KIND_CANCEL, 32'h1, 32'h0);
		issue_job(KIND_PUSH, 32'h5, 32'h6);
		issue_job(KIND_POP, 32'h0, 32'h0);

		// capacity two: full refusal, wrap, cancel across the wrap
		write_capacity(CAP_W'(2));
		issue_job(KIND_PUSH, 32'hA, 32'h10);
		issue_job(KIND_PUSH, 32'hB, 32'h11);
		issue_job(KIND_PUSH, 32'hC, 32'h12);
		issue_job(KIND_POP, 32'h0, 32'h0);
		issue_job(KIND_PUSH, 32'hD, 32'h13);
		issue_job(KIND_CANCEL, 32'hB, 32'h0);
		issue_job(KIND_POP, 32'h0, 32'h0);

		// random phases, each with its own capacity, tag pool and push bias
		for (int phase = 0; phase < 14; phase++) begin
			case (phase)
				0: cap = CAP_W'(31);
				1: cap = CAP_W'(0);
				2: cap = CAP_W'(16);
				3: cap = CAP_W'(1);
				4: cap = CAP_W'(17);
				default: begin
					r = $urandom_range(0, 9);
					if (r < 6) cap = CAP_W'($urandom_range(1, 6));
					else if (r < 8) cap = CAP_W'($urandom_range(7, 16));
					else cap = CAP_W'($urandom_range(0, 31));
				end
			endcase
			write_capacity(cap);
			foreach (tag_pool[i]) tag_pool[i] = $urandom;
			if (phase % 2 == 0) begin
				tag_pool[0] = 32'h0000_0000;
				tag_pool[1] = 32'hFFFF_FFFF;
			end
			push_w = $urandom_range(35, 65);
			quiet = (phase % 4 == 3);
			burst_left = $urandom_range(1, 20);
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 9) < 8) t = tag_pool[$urandom_range(0, 7)];
				else t = $urandom;
				r = $urandom_range(0, 99);
				if (r < 4) issue_job(KIND_UNUSED, t, $urandom);
				else if (r < 4 + push_w) issue_job(KIND_PUSH, t, $urandom);
				else if (r < 4 + push_w + (96 - push_w) / 2) issue_job(KIND_POP, t, $urandom);
				else issue_job(KIND_CANCEL, t, $urandom);
				burst_left--;
				if (burst_left == 0) begin
					if (!quiet) pause_sender($urandom_range(1, 8));
					burst_left = $urandom_range(1, 20);
				end
			end
		end

		drain_jobs();
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/jqc_pkg.sv
hw/rtl/jqc_ram.sv
hw/rtl/job_queue_with_cancel_core.sv
test/jqc_queue_checker.sv
test/job_queue_with_cancel_core_test.sv
